[design/thsd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Thermal serial deframer package
// Packet geometry constants and the types passed between the deframer blocks.
// ----------------------------------------------------------------------------
package thsd_pkg;

    localparam int unsigned PACKET_BYTES      = 164;
    localparam int unsigned PACKETS_PER_IMAGE = 60;
    localparam int unsigned HEADER_BYTES      = 4;
    localparam int unsigned PIXELS_PER_PACKET = (PACKET_BYTES - HEADER_BYTES) / 2;

    localparam logic [7:0]  POS_INDEX  = 8'd1;
    localparam logic [7:0]  POS_HEADER = 8'(HEADER_BYTES);
    localparam logic [7:0]  POS_LAST   = 8'(PACKET_BYTES - 1);
    localparam logic [5:0]  ROW_LAST   = 6'(PACKETS_PER_IMAGE - 1);
    localparam logic [6:0]  COL_LAST   = 7'(PIXELS_PER_PACKET - 1);
    localparam logic [6:0]  COL_COUNT  = 7'(PIXELS_PER_PACKET);
    localparam logic [5:0]  ROW_COUNT  = 6'(PACKETS_PER_IMAGE);

    localparam logic [15:0] PIXEL_MAX  = 16'hFFFF;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;

    // Result kinds.
    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // What the framer found in one byte.
    typedef struct packed {
        logic        restart;
        logic        pixel;
        logic        last;
        logic [5:0]  row;
        logic [6:0]  column;
        logic [15:0] value;
    } t_event;

    // Statistics that travel with a result.
    typedef struct packed {
        logic [15:0] frame_min;
        logic [15:0] frame_max;
        logic [15:0] resync_count;
    } t_stats;

endpackage
`default_nettype wire

[design/thsd_framer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Thermal serial deframer: packet framer
// Tracks the byte position and packet index, checks the index byte and
// joins payload byte pairs into pixels.
// ----------------------------------------------------------------------------
module thsd_framer (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_byte,
    output thsd_pkg::t_event     o_ev
);
    import thsd_pkg::*;

    logic [7:0] r_pos,  n_pos;
    logic [5:0] r_exp,  n_exp;
    logic [7:0] r_held, n_held;
    logic       r_skip, n_skip;

    logic [7:0] off;
    logic [6:0] col;
    logic [5:0] exp_inc;

    assign off     = r_pos - POS_HEADER;
    assign col     = off[7:1];
    assign exp_inc = r_exp + 6'd1;

    always_comb begin
        n_pos  = r_pos;
        n_exp  = r_exp;
        n_held = r_held;
        n_skip = r_skip;
        o_ev   = '0;
        if (!r_skip) begin
            if (r_pos == POS_INDEX) begin
                if (i_byte != {2'b00, r_exp}) begin
                    n_skip     = 1'b1;
                    n_exp      = '0;
                    o_ev.restart = 1'b1;
                end
            end else if (r_pos >= POS_HEADER && col < COL_COUNT) begin
                if (!off[0]) begin
                    n_held = i_byte;
                end else begin
                    o_ev.pixel  = 1'b1;
                    o_ev.row    = r_exp;
                    o_ev.column = col;
                    o_ev.value  = {r_held, i_byte};
                    o_ev.last   = (r_exp == ROW_LAST) && (col == COL_LAST);
                end
            end
        end
        if (r_pos >= POS_LAST) begin
            n_pos = '0;
            // A packet that was skipped leaves the index at zero.
            if (!n_skip) begin
                n_exp = (exp_inc >= ROW_COUNT) ? 6'd0 : exp_inc;
            end
            n_skip = 1'b0;
        end else begin
            n_pos = r_pos + 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_exp  <= '0;
            r_held <= '0;
            r_skip <= 1'b0;
        end else if (i_step) begin
            r_pos  <= n_pos;
            r_exp  <= n_exp;
            r_held <= n_held;
            r_skip <= n_skip;
        end
    end

endmodule
`default_nettype wire

[design/thsd_stats.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Thermal serial deframer: frame statistics
// Running minimum and maximum of the frame and the saturating resync count.
// ----------------------------------------------------------------------------
module thsd_stats (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire thsd_pkg::t_event i_ev,
    output thsd_pkg::t_stats     o_stats
);
    import thsd_pkg::*;

    logic [15:0] r_min, n_min;
    logic [15:0] r_max, n_max;
    logic [15:0] r_cnt, n_cnt;
    logic [15:0] px_min, px_max;

    assign px_min = (i_ev.value < r_min) ? i_ev.value : r_min;
    assign px_max = (i_ev.value > r_max) ? i_ev.value : r_max;

    always_comb begin
        n_min   = r_min;
        n_max   = r_max;
        n_cnt   = r_cnt;
        o_stats = '0;
        if (i_ev.restart) begin
            n_cnt = (r_cnt != COUNT_MAX) ? r_cnt + 16'd1 : r_cnt;
            n_min = PIXEL_MAX;
            n_max = '0;
            o_stats.resync_count = n_cnt;
        end else if (i_ev.pixel) begin
            o_stats.frame_min    = px_min;
            o_stats.frame_max    = px_max;
            o_stats.resync_count = r_cnt;
            // The extremes start afresh once the frame's last pixel is out.
            n_min = i_ev.last ? PIXEL_MAX : px_min;
            n_max = i_ev.last ? 16'd0 : px_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= PIXEL_MAX;
            r_max <= '0;
            r_cnt <= '0;
        end else if (i_step) begin
            r_min <= n_min;
            r_max <= n_max;
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

[design/thermal_spi_frame_deframer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Thermal serial frame deframer
// Splits the camera byte stream into packets and frames and emits pixels.
// ----------------------------------------------------------------------------
// One byte is taken in every cycle while the result side is not stalling.
// A byte passes an input register, the framing and statistics logic and a
// result register, which drives its result, if any, on the result ports.
// The input stalls only while a byte is held and the result waiting ahead
// of it is stalled. Header bytes, the first byte of each pixel pair and
// bytes of a skipped packet give no result; a packet index mismatch gives
// one restart result with the updated resync count.
module thermal_spi_frame_deframer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    output logic             o_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_res_valid,
    input  wire logic        i_res_stall,
    output logic             o_kind,
    output logic [5:0]       o_row,
    output logic [6:0]       o_column,
    output logic [15:0]      o_pixel,
    output logic             o_frame_end,
    output logic [15:0]      o_frame_min,
    output logic [15:0]      o_frame_max,
    output logic [15:0]      o_resync_count
);
    import thsd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       advance;
    logic       step;
    t_event     ev;
    t_stats     stats;

    assign advance    = !r_out_valid || !i_res_stall;
    assign step       = r_in_valid && advance;
    assign o_rx_stall = r_in_valid && !advance;
    assign o_res_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_rx_stall) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_rx_stall && i_rx_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    thsd_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_ev    (ev)
    );

    thsd_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_ev    (ev),
        .o_stats (stats)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && (ev.restart || ev.pixel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && (ev.restart || ev.pixel)) begin
            o_kind         <= ev.restart ? KIND_RESTART : KIND_PIXEL;
            o_row          <= ev.row;
            o_column       <= ev.column;
            o_pixel        <= ev.value;
            o_frame_end    <= ev.last;
            o_frame_min    <= stats.frame_min;
            o_frame_max    <= stats.frame_max;
            o_resync_count <= stats.resync_count;
        end
    end

`ifndef ASSERT_OFF
    a_restart_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == KIND_RESTART) |->
            (o_resync_count != 16'd0 && o_pixel == 16'd0 && o_frame_end == 1'b0))
        else $error("restart result without a counted resync");

    a_frame_end_place: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_frame_end) |->
            (o_kind == KIND_PIXEL && o_row == ROW_LAST && o_column == COL_LAST))
        else $error("frame end away from the last pixel");

    a_extremes_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_kind == KIND_PIXEL) |->
            (o_frame_min <= o_pixel && o_pixel <= o_frame_max))
        else $error("pixel outside the frame extremes");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_stall |-> (o_res_valid && i_res_stall))
        else $error("input stalled without a stalled result");
`endif

endmodule
`default_nettype wire

[test/deframer_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer result checker
// Watches both channels of the thermal serial deframer. It keeps its own
// model of the packet and frame state, works out the result that each
// accepted byte should cause, and compares every result transfer with the
// oldest outstanding prediction.
// ----------------------------------------------------------------------------
module deframer_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rx_valid,
    input  wire logic        i_rx_stall,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_stall,
    input  wire logic        i_kind,
    input  wire logic [5:0]  i_row,
    input  wire logic [6:0]  i_column,
    input  wire logic [15:0] i_pixel,
    input  wire logic        i_frame_end,
    input  wire logic [15:0] i_frame_min,
    input  wire logic [15:0] i_frame_max,
    input  wire logic [15:0] i_resync_count,
    output int unsigned      o_fail_count,
    output int unsigned      o_pending
);
    import thsd_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [5:0]  row;
        logic [6:0]  column;
        logic [15:0] pixel;
        logic        frame_end;
        logic [15:0] frame_min;
        logic [15:0] frame_max;
        logic [15:0] resync_count;
    } t_frame_result;

    t_frame_result frame_result_q[$];
    t_frame_result oldest;

    // Model of the framing state.
    logic [7:0]  byte_pos;
    logic [5:0]  row_expected;
    logic [7:0]  high_byte;
    logic        skipping;
    logic [15:0] run_min;
    logic [15:0] run_max;
    logic [15:0] resyncs;

    int unsigned fail_count   = 0;
    int unsigned pending      = 0;
    int unsigned results_seen = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    task automatic report_mismatch(input string msg);
        if (fail_count < 200) begin
            $display("mismatch at result %0d: %s", results_seen, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    // Advances the model by one received byte and queues the result it causes, if any.
    task automatic deframe_byte(input logic [7:0] rx);
        t_frame_result r;
        logic [7:0]    offset;
        logic [6:0]    col;
        logic [15:0]   px;
        logic [5:0]    next_row;
        r = '0;
        if (!skipping) begin
            if (byte_pos == POS_INDEX) begin
                // All eight bits take part, so an index above 63 never matches.
                if (rx != {2'b00, row_expected}) begin
                    skipping     = 1'b1;
                    row_expected = '0;
                    if (resyncs != COUNT_MAX) begin
                        resyncs = resyncs + 16'd1;
                    end
                    run_min        = PIXEL_MAX;
                    run_max        = '0;
                    r.kind         = KIND_RESTART;
                    r.resync_count = resyncs;
                    frame_result_q.push_back(r);
                end
            end else if (byte_pos >= POS_HEADER) begin
                offset = byte_pos - POS_HEADER;
                col    = offset[7:1];
                if (col < COL_COUNT) begin
                    if (!offset[0]) begin
                        high_byte = rx;
                    end else begin
                        px = {high_byte, rx};
                        if (px < run_min) begin
                            run_min = px;
                        end
                        if (px > run_max) begin
                            run_max = px;
                        end
                        r.kind         = KIND_PIXEL;
                        r.row          = row_expected;
                        r.column       = col;
                        r.pixel        = px;
                        r.frame_end    = (row_expected == ROW_LAST) && (col == COL_LAST);
                        r.frame_min    = run_min;
                        r.frame_max    = run_max;
                        r.resync_count = resyncs;
                        frame_result_q.push_back(r);
                        if (r.frame_end) begin
                            run_min = PIXEL_MAX;
                            run_max = '0;
                        end
                    end
                end
            end
        end
        if (byte_pos >= POS_LAST) begin
            byte_pos = '0;
            if (!skipping) begin
                next_row     = row_expected + 6'd1;
                row_expected = (next_row >= ROW_COUNT) ? '0 : next_row;
            end
            skipping = 1'b0;
        end else begin
            byte_pos = byte_pos + 8'd1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_pos     = '0;
            row_expected = '0;
            high_byte    = '0;
            skipping     = 1'b0;
            run_min      = PIXEL_MAX;
            run_max      = '0;
            resyncs      = '0;
            frame_result_q.delete();
        end else begin
            // A result leaves only after its byte has passed the input register and the
            // result register, so the result side is handled first.
            if (i_res_valid && !i_res_stall) begin
                if (frame_result_q.size() == 0) begin
                    report_mismatch("result transfer with nothing expected");
                end else begin
                    oldest = frame_result_q.pop_front();
                    check_field("kind", 16'(i_kind), 16'(oldest.kind));
                    check_field("row", 16'(i_row), 16'(oldest.row));
                    check_field("column", 16'(i_column), 16'(oldest.column));
                    check_field("pixel", i_pixel, oldest.pixel);
                    check_field("frame_end", 16'(i_frame_end), 16'(oldest.frame_end));
                    check_field("frame_min", i_frame_min, oldest.frame_min);
                    check_field("frame_max", i_frame_max, oldest.frame_max);
                    check_field("resync_count", i_resync_count, oldest.resync_count);
                end
                results_seen++;
            end
            if (i_rx_valid && !i_rx_stall) begin
                deframe_byte(i_rx_byte);
            end
        end
        pending = frame_result_q.size();
    end

endmodule
`default_nettype wire

[test/thermal_spi_frame_deframer_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Thermal serial frame deframer testbench
// Feeds the deframer whole packets of camera bytes, clean ones and ones
// broken by a wrong packet index, with random idling on both channels.
// A checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module thermal_spi_frame_deframer_test;
    import thsd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PAYLOAD     = PACKET_BYTES - HEADER_BYTES;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_rx_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = '0;
    logic        i_res_stall = 1'b0;
    logic        o_rx_stall;
    logic        o_res_valid;
    logic        o_kind;
    logic [5:0]  o_row;
    logic [6:0]  o_column;
    logic [15:0] o_pixel;
    logic        o_frame_end;
    logic [15:0] o_frame_min;
    logic [15:0] o_frame_max;
    logic [15:0] o_resync_count;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned cycle_count = 0;

    bit          idle_on  = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned row_next = 0;

    thermal_spi_frame_deframer dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_kind         (o_kind),
        .o_row          (o_row),
        .o_column       (o_column),
        .o_pixel        (o_pixel),
        .o_frame_end    (o_frame_end),
        .o_frame_min    (o_frame_min),
        .o_frame_max    (o_frame_max),
        .o_resync_count (o_resync_count)
    );

    deframer_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .i_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .i_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .i_kind         (o_kind),
        .i_row          (o_row),
        .i_column       (o_column),
        .i_pixel        (o_pixel),
        .i_frame_end    (o_frame_end),
        .i_frame_min    (o_frame_min),
        .i_frame_max    (o_frame_max),
        .i_resync_count (o_resync_count),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: stall bursts, free-running stretches and one long hold-off.
    initial begin
        forever begin
            if (hold_req) begin
                i_res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                i_res_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_res_stall <= 1'b0;
                repeat ($urandom_range(1, 24)) @(posedge i_clk);
            end
        end
    end

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    // Offers one byte and returns at the edge where the transfer happens.
    task automatic send_byte(input logic [7:0] value);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= value;
        @(posedge i_clk);
        while (o_rx_stall) @(posedge i_clk);
    endtask

    // Sends the four header bytes and follows the index the block will expect.
    task automatic send_header(input logic [7:0] index);
        send_byte(8'($urandom()));
        send_byte(index);
        send_byte(8'($urandom()));
        send_byte(8'($urandom()));
        if (index == 8'(row_next)) begin
            row_next = (row_next + 1) % PACKETS_PER_IMAGE;
        end else begin
            row_next = 0;
        end
    endtask

    task automatic send_payload(input int unsigned count);
        repeat (count) send_byte(payload_byte());
    endtask

    task automatic send_packet(input logic [7:0] index);
        send_header(index);
        send_payload(PAYLOAD);
    endtask

    // Picks an index byte that cannot match the expected packet.
    function automatic logic [7:0] wrong_index();
        case ($urandom_range(0, 2))
            0:       return 8'(($urandom_range(1, PACKETS_PER_IMAGE - 1) + row_next)
                               % PACKETS_PER_IMAGE);
            1:       return 8'($urandom_range(64, 255));
            default: return {2'($urandom_range(1, 3)), 6'(row_next)};
        endcase
    endfunction

    task automatic drain_results();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pixel extremes at the start of the first packet.
        send_header(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h01);
        send_payload(PAYLOAD - 10);
        // Low six bits equal the expected index but the upper bits do not.
        send_packet({2'b01, 6'(row_next)});

        for (int attempt = 0; attempt < 9; attempt++) begin
            idle_on = (attempt < 7) && (attempt != 5);
            if (attempt == 1) begin
                hold_req = 1'b1;
            end
            if (attempt == 3 || attempt == 6 ||
                    (attempt != 1 && $urandom_range(0, 3) == 0)) begin
                send_packet(wrong_index());
            end else begin
                send_packet(8'(row_next));
            end
            if (attempt == 2) begin
                drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

[thermal_spi_frame_deframer.f]
design/thsd_pkg.sv
design/thsd_framer.sv
design/thsd_stats.sv
design/thermal_spi_frame_deframer.sv
test/deframer_checker.sv
test/thermal_spi_frame_deframer_test.sv
